### rtl/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants of the sticky shift filter
// Holds the register map, the latch mode type, the action word that travels
// from the front to the back, and the queue status group.
// ----------------------------------------------------------------------------
package ssf_pkg;

   // Width of the three saturating elapsed counters.
   localparam int CNT_W = 16;
   localparam int CFG_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int Q_DEPTH = 2;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_WINDOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_TAP_WINDOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_KEY_CODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_EVENT_TYPE = 3'd4;

   // Reset values of the registers.
   localparam logic [CFG_W-1:0] TAP_WINDOW_RESET = 16'd150;
   localparam logic [CFG_W-1:0] DOUBLE_TAP_WINDOW_RESET = 16'd300;
   localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RESET = 16'd3000;
   localparam logic [CFG_W-1:0] SHIFT_KEY_CODE_RESET = 16'd42;
   localparam logic [CFG_W-1:0] KEY_EVENT_TYPE_RESET = 16'd1;

   // Command codes and key values.
   localparam logic CMD_TICK = 1'b0;
   localparam logic signed [31:0] KEY_VALUE_DOWN = 32'sd1;
   localparam logic signed [31:0] KEY_VALUE_REPEAT = 32'sd2;
   localparam logic signed [31:0] KEY_VALUE_UP = 32'sd0;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_LATCHED = 2'd1,
      MODE_HELD    = 2'd2,
      MODE_LOCKED  = 2'd3
   } mode_type;

   // What the back has to send for one accepted item.
   typedef enum logic [1:0] {
      ACT_PASS    = 2'd0,
      ACT_UP      = 2'd1,
      ACT_PASS_UP = 2'd2
   } act_kind_type;

   typedef struct packed {
      logic [CFG_W-1:0] tap_window;
      logic [CFG_W-1:0] double_tap_window;
      logic [CFG_W-1:0] idle_timeout;
      logic [CFG_W-1:0] shift_key_code;
      logic [CFG_W-1:0] key_event_type;
   } cfg_type;

   typedef struct packed {
      act_kind_type       kind;
      logic [15:0]        ev_type;
      logic [15:0]        ev_code;
      logic signed [31:0] ev_value;
   } action_type;

   typedef struct packed {
      logic               full;
      logic               empty;
      logic [Q_CNT_W-1:0] count;
   } q_status_type;

   // Saturating increment of an elapsed counter.
   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      r = (&c) ? c : c + 1'b1;
      return r;
   endfunction

endpackage

### rtl/sticky_shift_filter_top.sv
// ----------------------------------------------------------------------------
// sticky_shift_filter_top: sticky shift latch for a stream of input events
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: type, code, value; tuser: command
// rsp      out  rsp_tvalid/tready    tdata: type, code, value; tlast: last
// csr      in   csr_valid/csr_ready  csr_index, csr_data
//
// The front takes a word every cycle while the two-entry queue has room; a
// result word leaves the output register every cycle the sink is ready, so
// an item with two results holds the back until both words have left.
// A queued action's first word is loaded once the output register is free.
// Reset is synchronous and resets the mode, counters, queue and output.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module sticky_shift_filter_top
   import ssf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [15:0] event_type, [31:16] event_code, [63:32] event_value
   input  logic [63:0]          req_tdata,
   // [0] command
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [15:0] out_type, [31:16] out_code, [63:32] out_value
   output logic [63:0]          rsp_tdata,
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   cfg_type            cfg;
   logic               accept;
   logic               enq_valid;
   action_type         enq_action;
   action_type         head;
   q_status_type       q_status;
   logic               pop;
   logic [15:0]        out_type;
   logic [15:0]        out_code;
   logic signed [31:0] out_value;

   assign csr_ready = 1'b1;
   assign req_tready = !q_status.full;
   assign accept = req_tvalid && req_tready;
   assign rsp_tdata = {out_value, out_code, out_type};

   ssf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .cmd        (req_tuser),
      .ev_type    (req_tdata[15:0]),
      .ev_code    (req_tdata[31:16]),
      .ev_value   (req_tdata[63:32]),
      .cfg        (cfg),
      .enq_valid  (enq_valid),
      .enq_action (enq_action)
   );

   ssf_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (enq_valid),
      .push_action (enq_action),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   ssf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_type   (out_type),
      .out_code   (out_code),
      .out_value  (out_value),
      .out_last   (rsp_tlast)
   );

   // The queue never holds more actions than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= Q_CNT_W'(Q_DEPTH))
      else $error("action queue overfilled");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // A word that is not the last of its run is followed at once by the
   // synthetic shift release.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tlast && rsp_tdata[31:16] == cfg.shift_key_code)
      else $error("second result of a pass-then-release missing");

endmodule

### rtl/ssf_front.sv
// ----------------------------------------------------------------------------
// ssf_front: configuration, latch state machine and item classification
// Accepts one word a cycle while the queue has room, updates the latch mode
// and the elapsed counters, and pushes one action for each item that causes
// a result.
// ----------------------------------------------------------------------------
module ssf_front
   import ssf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 accept,
   input  logic                 cmd,
   input  logic [15:0]          ev_type,
   input  logic [15:0]          ev_code,
   input  logic signed [31:0]   ev_value,
   output cfg_type              cfg,
   output logic                 enq_valid,
   output action_type           enq_action
);

   cfg_type          cfg_ff;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] since_shift_down_ff, since_shift_down_in;
   logic [CNT_W-1:0] since_mode_change_ff, since_mode_change_in;
   logic [CNT_W-1:0] since_last_key_ff, since_last_key_in;
   logic [CNT_W-1:0] last_key_bumped;
   logic             tap;
   logic             double_tap;
   logic             idle_expired;

   assign cfg = cfg_ff;

   // Configuration registers; indexes past the map are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_window <= TAP_WINDOW_RESET;
         cfg_ff.double_tap_window <= DOUBLE_TAP_WINDOW_RESET;
         cfg_ff.idle_timeout <= IDLE_TIMEOUT_RESET;
         cfg_ff.shift_key_code <= SHIFT_KEY_CODE_RESET;
         cfg_ff.key_event_type <= KEY_EVENT_TYPE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TAP_WINDOW: cfg_ff.tap_window <= csr_data;
            CSR_DOUBLE_TAP_WINDOW: cfg_ff.double_tap_window <= csr_data;
            CSR_IDLE_TIMEOUT: cfg_ff.idle_timeout <= csr_data;
            CSR_SHIFT_KEY_CODE: cfg_ff.shift_key_code <= csr_data;
            CSR_KEY_EVENT_TYPE: cfg_ff.key_event_type <= csr_data;
            default: ;
         endcase
      end
   end

   // Mode register and elapsed counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         since_shift_down_ff <= '1;
         since_mode_change_ff <= '0;
         since_last_key_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         since_shift_down_ff <= since_shift_down_in;
         since_mode_change_ff <= since_mode_change_in;
         since_last_key_ff <= since_last_key_in;
      end
   end

   // Compares run at 32 bits so that any counter width lines up with the
   // 16-bit windows.
   assign last_key_bumped = bump(since_last_key_ff);
   assign idle_expired = 32'(last_key_bumped) > 32'(cfg_ff.idle_timeout);
   assign tap = 32'(since_shift_down_ff) < 32'(cfg_ff.tap_window);
   assign double_tap = tap &&
      (32'(since_mode_change_ff) < 32'(cfg_ff.double_tap_window));

   // Next mode, counters and the action for the accepted word.
   always_comb begin
      mode_in = mode_ff;
      since_shift_down_in = since_shift_down_ff;
      since_mode_change_in = since_mode_change_ff;
      since_last_key_in = since_last_key_ff;
      enq_valid = 1'b0;
      enq_action.kind = ACT_PASS;
      enq_action.ev_type = ev_type;
      enq_action.ev_code = ev_code;
      enq_action.ev_value = ev_value;

      if (accept) begin
         if (cmd == CMD_TICK) begin
            since_shift_down_in = bump(since_shift_down_ff);
            since_mode_change_in = bump(since_mode_change_ff);
            since_last_key_in = last_key_bumped;
            if (mode_ff != MODE_IDLE && idle_expired) begin
               mode_in = MODE_IDLE;
               since_mode_change_in = '0;
               enq_valid = 1'b1;
               enq_action.kind = ACT_UP;
            end
         end else if (ev_type != cfg_ff.key_event_type) begin
            enq_valid = 1'b1;
         end else begin
            since_last_key_in = '0;
            if (ev_code != cfg_ff.shift_key_code) begin
               // An ordinary key; a latched shift is spent on it.
               enq_valid = 1'b1;
               if (mode_ff == MODE_LATCHED) begin
                  enq_action.kind = ACT_PASS_UP;
                  mode_in = MODE_IDLE;
                  since_mode_change_in = '0;
               end
            end else if (ev_value == KEY_VALUE_REPEAT) begin
               // Shift repeats are dropped.
            end else if (ev_value == KEY_VALUE_DOWN) begin
               since_shift_down_in = '0;
               unique case (mode_ff)
                  MODE_IDLE: enq_valid = 1'b1;
                  MODE_LATCHED, MODE_HELD: begin
                     mode_in = MODE_HELD;
                     since_mode_change_in = '0;
                  end
                  default: ;
               endcase
            end else begin
               // Any other shift value counts as a release.
               unique case (mode_ff)
                  MODE_IDLE: begin
                     if (tap) begin
                        mode_in = MODE_LATCHED;
                        since_mode_change_in = '0;
                     end else begin
                        enq_valid = 1'b1;
                     end
                  end
                  MODE_LATCHED, MODE_HELD: begin
                     since_mode_change_in = '0;
                     if (double_tap) begin
                        mode_in = MODE_LOCKED;
                     end else begin
                        mode_in = MODE_IDLE;
                        enq_valid = 1'b1;
                        enq_action.kind = ACT_UP;
                     end
                  end
                  default: begin
                     mode_in = MODE_IDLE;
                     since_mode_change_in = '0;
                     enq_valid = 1'b1;
                     enq_action.kind = ACT_UP;
                  end
               endcase
            end
         end
      end
   end

endmodule

### rtl/ssf_queue.sv
// ----------------------------------------------------------------------------
// ssf_queue: two-entry action queue between front and back
// Register-based FIFO; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ssf_queue
   import ssf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  action_type   push_action,
   input  logic         pop,
   output action_type   head,
   output q_status_type status
);

   localparam int PTR_W = $clog2(Q_DEPTH);

   action_type         entry_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff;
   logic               do_push;
   logic               do_pop;

   assign status.full = count_ff == Q_CNT_W'(Q_DEPTH);
   assign status.empty = count_ff == '0;
   assign status.count = count_ff;
   assign head = entry_ff[rd_ptr_ff];
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_action;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/ssf_back.sv
// ----------------------------------------------------------------------------
// ssf_back: result sequencer
// Turns each queued action into one or two result words and holds the
// current word in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module ssf_back
   import ssf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  action_type         head,
   input  logic               head_valid,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [15:0]        out_type,
   output logic [15:0]        out_code,
   output logic signed [31:0] out_value,
   output logic               out_last
);

   logic               valid_ff;
   logic               second_ff, second_in;
   logic [15:0]        type_ff, type_in;
   logic [15:0]        code_ff, code_in;
   logic signed [31:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic               load;
   logic               send_up;

   assign out_valid = valid_ff;
   assign out_type = type_ff;
   assign out_code = code_ff;
   assign out_value = value_ff;
   assign out_last = last_ff;

   // The output register takes a new word when it is empty or being drained.
   assign load = head_valid && (!valid_ff || out_ready);
   assign send_up = (head.kind == ACT_UP) || second_ff;

   // Pick the word for the head action and decide whether it is finished.
   always_comb begin
      second_in = second_ff;
      pop = 1'b0;
      last_in = 1'b1;
      if (send_up) begin
         type_in = cfg.key_event_type;
         code_in = cfg.shift_key_code;
         value_in = KEY_VALUE_UP;
      end else begin
         type_in = head.ev_type;
         code_in = head.ev_code;
         value_in = head.ev_value;
      end
      if (load) begin
         if (head.kind == ACT_PASS_UP && !second_ff) begin
            second_in = 1'b1;
            last_in = 1'b0;
         end else begin
            second_in = 1'b0;
            pop = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (load) begin
         type_ff <= type_in;
         code_ff <= code_in;
         value_ff <= value_in;
         last_ff <= last_in;
      end
   end

endmodule
